// ----- rtl/sgrt_pkg.sv -----
// ----------------------------------------------------------------------------
// sgrt_pkg
// Shared types, codes and sizes of the sensor gate run timer.
// ----------------------------------------------------------------------------
package sgrt_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int K_W          = $clog2(SENSOR_COUNT);

    localparam int OP_W    = 2;
    localparam int PORT_W  = 8;
    localparam int TIME_W  = 32;
    localparam int MASK_W  = 8;
    localparam int COUNT_W = 4;
    localparam int TMO_W   = 16;
    localparam int SETL_W  = 16;
    localparam int RETR_W  = 24;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 56;

    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd10000;
    localparam logic [SETL_W-1:0] SETTLE_RST  = 16'd100;
    localparam logic [RETR_W-1:0] RETRIG_RST  = 24'd1000;

    typedef enum logic [CIDX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_SETTLE  = 2'd1,
        REG_RETRIG  = 2'd2,
        REG_SPARE   = 2'd3
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_ARM    = 2'd0,
        OP_DISARM = 2'd1,
        OP_POLL   = 2'd2,
        OP_EVENT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_ARMED     = 2'd1,
        MODE_MEASURING = 2'd2,
        MODE_COMPLETE  = 2'd3
    } mode_t;

    // forward is end A toward end B
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic arm;
        logic disarm;
        logic timeout;
        logic scan_step;
        logic wrap;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t   op;
        mode_t mode;
        logic  timeout_hit;
        logic  settle_hit;
        logic  scan_last;
    } stat_t;

endpackage

// ----- rtl/sgrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// sgrt_ctrl
// Sequencer: takes an item, decides on it, steps the sensor scan and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module sgrt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  sgrt_pkg::stat_t   stat,
    output sgrt_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_DECIDE,
        S_SCAN,
        S_WRAP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_WAIT);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_WAIT: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_FINISH;
                priority if (stat.op == sgrt_pkg::OP_ARM) begin
                    cmd.arm = 1'b1;
                end else if (stat.op == sgrt_pkg::OP_DISARM) begin
                    cmd.disarm = 1'b1;
                end else if (stat.mode == sgrt_pkg::MODE_MEASURING && stat.timeout_hit) begin
                    cmd.timeout = 1'b1;
                end else if ((stat.mode == sgrt_pkg::MODE_MEASURING ||
                              stat.mode == sgrt_pkg::MODE_ARMED) &&
                             stat.op == sgrt_pkg::OP_EVENT &&
                             !(stat.mode == sgrt_pkg::MODE_ARMED && stat.settle_hit)) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            default: begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_WAIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- rtl/sgrt_dp.sv -----
// ----------------------------------------------------------------------------
// sgrt_dp
// Datapath: configuration, run record, timestamp store, running first and
// latest stamps, one sensor checked per scan step, and the output register.
// ----------------------------------------------------------------------------
module sgrt_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sgrt_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [sgrt_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [sgrt_pkg::OP_W-1:0]           in_op,
    input  logic [sgrt_pkg::IN_DATA_W-1:0]      in_data,
    output logic [sgrt_pkg::OUT_DATA_W-1:0]     out_data,
    input  sgrt_pkg::cmd_t                      cmd,
    output sgrt_pkg::stat_t                     stat
);

    localparam int N    = sgrt_pkg::SENSOR_COUNT;
    localparam int TW   = sgrt_pkg::TIME_W;
    localparam int LAST = N - 1;

    logic [sgrt_pkg::TMO_W-1:0]   timeout_reg;
    logic [sgrt_pkg::SETL_W-1:0]  settle_reg;
    logic [sgrt_pkg::RETR_W-1:0]  retrig_reg;

    sgrt_pkg::op_t                op_reg;
    logic [N-1:0]                 active_reg;
    logic [TW-1:0]                ts_reg;
    logic [TW-1:0]                now_reg;

    sgrt_pkg::mode_t              mode_reg;
    logic [N-1:0]                 recorded_reg;
    logic [TW-1:0]                stamp_reg [N];
    logic [sgrt_pkg::COUNT_W-1:0] count_reg;
    logic [1:0]                   dir_reg;
    logic [TW-1:0]                run_start_reg;
    logic [TW-1:0]                arm_moment_reg;
    logic [TW-1:0]                duration_reg;
    logic [TW-1:0]                latest_reg;
    logic [TW-1:0]                first_reg;
    logic                         done_reg;
    logic [sgrt_pkg::K_W-1:0]     k_reg;
    logic [sgrt_pkg::OUT_DATA_W-1:0] out_reg;

    logic [TW-1:0] run_age;
    logic [TW-1:0] arm_age;
    logic [TW-1:0] since_latest;
    logic          take_k;
    logic          end_a;
    logic          end_b;

    assign run_age      = now_reg - run_start_reg;
    assign arm_age      = now_reg - arm_moment_reg;
    assign since_latest = ts_reg - latest_reg;

    // sensor k is new, active and clear of the retrigger guard
    assign take_k = !recorded_reg[k_reg] && active_reg[k_reg] &&
                    !(count_reg != '0 &&
                      since_latest < {{(TW-sgrt_pkg::RETR_W){1'b0}}, retrig_reg});

    assign end_a = recorded_reg[0];
    assign end_b = recorded_reg[LAST];

    assign stat.op          = op_reg;
    assign stat.mode        = mode_reg;
    assign stat.timeout_hit = run_age > {{(TW-sgrt_pkg::TMO_W){1'b0}}, timeout_reg};
    assign stat.settle_hit  = arm_age < {{(TW-sgrt_pkg::SETL_W){1'b0}}, settle_reg};
    assign stat.scan_last   = (k_reg == sgrt_pkg::K_W'(LAST));

    assign out_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= sgrt_pkg::TIMEOUT_RST;
            settle_reg  <= sgrt_pkg::SETTLE_RST;
            retrig_reg  <= sgrt_pkg::RETRIG_RST;
        end else if (cfg_wr_en) begin
            unique case (sgrt_pkg::reg_idx_t'(cfg_index))
                sgrt_pkg::REG_TIMEOUT: timeout_reg <= cfg_wdata[sgrt_pkg::TMO_W-1:0];
                sgrt_pkg::REG_SETTLE:  settle_reg  <= cfg_wdata[sgrt_pkg::SETL_W-1:0];
                sgrt_pkg::REG_RETRIG:  retrig_reg  <= cfg_wdata[sgrt_pkg::RETR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // latched item, timestamp store writes and output payload
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg     <= sgrt_pkg::op_t'(in_op);
            active_reg <= ~in_data[N-1:0];
            ts_reg     <= in_data[8 +: TW];
            now_reg    <= in_data[40 +: TW];
        end
        if (cmd.load_out) begin
            out_reg <= {7'd0, duration_reg, count_reg,
                        {(sgrt_pkg::MASK_W-N){1'b0}}, recorded_reg,
                        dir_reg, done_reg, mode_reg};
        end
        if (cmd.scan_step && take_k) begin
            stamp_reg[k_reg] <= ts_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= sgrt_pkg::MODE_IDLE;
            recorded_reg   <= '0;
            count_reg      <= '0;
            dir_reg        <= sgrt_pkg::DIR_NONE;
            run_start_reg  <= '0;
            arm_moment_reg <= '0;
            duration_reg   <= '0;
            latest_reg     <= '0;
            first_reg      <= '1;
            done_reg       <= 1'b0;
            k_reg          <= '0;
        end else begin
            if (cmd.latch) begin
                done_reg <= 1'b0;
                k_reg    <= '0;
            end
            if (cmd.arm) begin
                recorded_reg   <= '0;
                count_reg      <= '0;
                dir_reg        <= sgrt_pkg::DIR_NONE;
                run_start_reg  <= '0;
                duration_reg   <= '0;
                latest_reg     <= '0;
                first_reg      <= '1;
                arm_moment_reg <= now_reg;
                mode_reg       <= sgrt_pkg::MODE_ARMED;
            end
            if (cmd.disarm) begin
                mode_reg <= sgrt_pkg::MODE_IDLE;
            end
            if (cmd.timeout) begin
                mode_reg <= sgrt_pkg::MODE_COMPLETE;
                done_reg <= 1'b1;
            end
            if (cmd.scan_step) begin
                k_reg <= k_reg + 1'b1;
                if (take_k) begin
                    recorded_reg[k_reg] <= 1'b1;
                    count_reg           <= count_reg + 1'b1;
                    if (ts_reg > latest_reg) begin
                        latest_reg <= ts_reg;
                    end
                    if (ts_reg < first_reg) begin
                        first_reg <= ts_reg;
                    end
                    if (count_reg == '0) begin
                        run_start_reg <= now_reg;
                        mode_reg      <= sgrt_pkg::MODE_MEASURING;
                    end
                end
            end
            if (cmd.wrap) begin
                if (dir_reg == sgrt_pkg::DIR_NONE && count_reg >= 4'd2) begin
                    priority if (end_a && end_b) begin
                        dir_reg <= (stamp_reg[0] < stamp_reg[LAST]) ?
                                   sgrt_pkg::DIR_FWD : sgrt_pkg::DIR_REV;
                    end else if (end_a) begin
                        dir_reg <= sgrt_pkg::DIR_FWD;
                    end else if (end_b) begin
                        dir_reg <= sgrt_pkg::DIR_REV;
                    end else begin
                        dir_reg <= sgrt_pkg::DIR_NONE;
                    end
                end
                if (count_reg >= sgrt_pkg::COUNT_W'(N)) begin
                    duration_reg <= latest_reg - first_reg;
                    mode_reg     <= sgrt_pkg::MODE_COMPLETE;
                    done_reg     <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/sensor_gate_run_timer_core.sv -----
// ----------------------------------------------------------------------------
// sensor_gate_run_timer_core
// Run timer for a row of optical gate sensors.
//
// Each input item carries an operation in s_tuser (arm, disarm, poll, poll
// with sensor event) and in s_tdata the captured port levels, the event
// microsecond stamp and the current millisecond time. Every item gives
// exactly one result item on the m_ channel: run state, done flag,
// direction, fired mask and count, and the run duration.
// An item is taken only when the previous one has left the sequencer. Arm,
// disarm, plain polls, dropped events and timeouts go from the decide state
// to the finish state, which loads the result; a scanned event goes through
// the scan states, one sensor per cycle through the retrigger compare, and
// the wrap state before the finish state. The result register lets a new item
// in while a result waits; if the receiver holds m_tready low the next result
// waits in the sequencer and no further item is taken. Reset (aresetn low,
// synchronous) clears the run record, puts the timer idle and loads the default
// timeout, settle and retrigger settings. Settings are written through cfg_wr_en
// by the user only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sensor_gate_run_timer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sgrt_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [sgrt_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // port_bits[7:0], event_us[39:8], now_ms[71:40]
    input  logic [sgrt_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation[1:0]
    input  logic [sgrt_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // run_state[1:0], run_done[2], direction[4:3], fired_mask[12:5],
    // fired_count[16:13], run_duration_us[48:17], zero fill [55:49]
    output logic [sgrt_pkg::OUT_DATA_W-1:0]     m_tdata
);

    sgrt_pkg::cmd_t  cmd;
    sgrt_pkg::stat_t stat;

    sgrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgrt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_tuser),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor gate run timer core. Items are sent on
// the s_ stream with random gaps, each accepted item is run through a local
// model of the run timer, and every m_ item is compared field by field with
// the oldest predicted result. Directed runs cover arming, settle drops,
// the retrigger guard, direction, completion, timeout and time wrap, then
// random phases under several settings run mostly well-formed gate runs.
// ----------------------------------------------------------------------------
module tb_top;
    import sgrt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PAD    = 12;
    localparam int PHASE_ITEMS = 65;

    typedef struct {
        mode_t             run_state;
        logic              run_done;
        logic [1:0]        direction;
        logic [MASK_W-1:0] fired_mask;
        logic [COUNT_W-1:0] fired_count;
        logic [TIME_W-1:0] duration;
    } gate_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    sensor_gate_run_timer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // local copy of the timer settings and run record
    logic [TMO_W-1:0]  cfg_timeout = TIMEOUT_RST;
    logic [SETL_W-1:0] cfg_settle  = SETTLE_RST;
    logic [RETR_W-1:0] cfg_retrig  = RETRIG_RST;

    mode_t             run_mode = MODE_IDLE;
    logic [MASK_W-1:0] fired = '0;
    logic [TIME_W-1:0] gate_stamp [SENSOR_COUNT];
    logic [COUNT_W-1:0] fired_num = '0;
    logic [1:0]        travel = DIR_NONE;
    logic [TIME_W-1:0] started_ms = '0;
    logic [TIME_W-1:0] armed_ms = '0;
    logic [TIME_W-1:0] spread_us = '0;

    gate_result_t      expected_results [$];

    int                mismatch_count = 0;
    int                items_sent = 0;
    int                cycle_count = 0;
    int                ready_hold = 0;
    logic              quiet = 1'b0;
    logic [TIME_W-1:0] stream_now = '0;
    logic [TIME_W-1:0] stream_us = '0;

    initial begin
        for (int k = 0; k < SENSOR_COUNT; k++) gate_stamp[k] = '0;
    end

    function automatic void clear_run();
        fired      = '0;
        fired_num  = '0;
        travel     = DIR_NONE;
        started_ms = '0;
        spread_us  = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) gate_stamp[k] = '0;
    endfunction

    // largest recorded stamp taken as a plain unsigned value
    function automatic logic [TIME_W-1:0] newest_stamp();
        logic [TIME_W-1:0] best;
        best = '0;
        for (int k = 0; k < SENSOR_COUNT; k++)
            if (fired[k] && gate_stamp[k] > best) best = gate_stamp[k];
        return best;
    endfunction

    function automatic logic record_event(logic [PORT_W-1:0] port, logic [TIME_W-1:0] ts,
                                          logic [TIME_W-1:0] now);
        logic [SENSOR_COUNT-1:0] active;
        logic [TIME_W-1:0]       since_arm;
        logic [TIME_W-1:0]       gap_us;
        logic [TIME_W-1:0]       first;
        logic [TIME_W-1:0]       last;
        logic                    end_a;
        logic                    end_b;
        active    = ~port[SENSOR_COUNT-1:0];
        since_arm = now - armed_ms;
        if (run_mode == MODE_ARMED && since_arm < TIME_W'(cfg_settle)) return 1'b0;

        for (int k = 0; k < SENSOR_COUNT; k++) begin
            if (fired[k] || !active[k]) continue;
            gap_us = ts - newest_stamp();
            if (fired_num != 0 && gap_us < TIME_W'(cfg_retrig)) continue;
            fired[k]      = 1'b1;
            gate_stamp[k] = ts;
            fired_num     = fired_num + 1'b1;
            if (fired_num == 1) begin
                started_ms = now;
                run_mode   = MODE_MEASURING;
            end
        end

        if (travel == DIR_NONE && fired_num >= 2) begin
            end_a = fired[0];
            end_b = fired[SENSOR_COUNT-1];
            if (end_a && end_b)
                travel = (gate_stamp[0] < gate_stamp[SENSOR_COUNT-1]) ? DIR_FWD : DIR_REV;
            else if (end_a)
                travel = DIR_FWD;
            else if (end_b)
                travel = DIR_REV;
        end

        if (fired_num >= SENSOR_COUNT) begin
            first = '1;
            last  = '0;
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                if (fired[k]) begin
                    if (gate_stamp[k] < first) first = gate_stamp[k];
                    if (gate_stamp[k] > last) last = gate_stamp[k];
                end
            end
            spread_us = last - first;
            run_mode  = MODE_COMPLETE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_gate(op_t op, logic [PORT_W-1:0] port,
                                         logic [TIME_W-1:0] ts, logic [TIME_W-1:0] now);
        gate_result_t      r;
        logic              done;
        logic [TIME_W-1:0] since_start;
        done = 1'b0;
        case (op)
            OP_ARM: begin
                clear_run();
                armed_ms = now;
                run_mode = MODE_ARMED;
            end
            OP_DISARM: run_mode = MODE_IDLE;
            default: begin
                if (run_mode == MODE_ARMED || run_mode == MODE_MEASURING) begin
                    since_start = now - started_ms;
                    if (run_mode == MODE_MEASURING && since_start > TIME_W'(cfg_timeout)) begin
                        run_mode = MODE_COMPLETE;
                        done     = 1'b1;
                    end else if (op == OP_EVENT) begin
                        done = record_event(port, ts, now);
                    end
                end
            end
        endcase
        r.run_state   = run_mode;
        r.run_done    = done;
        r.direction   = travel;
        r.fired_mask  = fired;
        r.fired_count = fired_num;
        r.duration    = spread_us;
        expected_results.push_back(r);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int source_gap();
        if (quiet || $urandom_range(0, 99) < 55) return 0;
        return gap_length();
    endfunction

    // receiver side: random back-pressure and result checking
    gate_result_t      want;
    logic [1:0]        got_state;
    logic              got_done;
    logic [1:0]        got_dir;
    logic [MASK_W-1:0] got_mask;
    logic [COUNT_W-1:0] got_count;
    logic [TIME_W-1:0] got_dur;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end

        if (aresetn && m_tvalid && m_tready) begin
            got_state = m_tdata[1:0];
            got_done  = m_tdata[2];
            got_dir   = m_tdata[4:3];
            got_mask  = m_tdata[12:5];
            got_count = m_tdata[16:13];
            got_dur   = m_tdata[48:17];
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result item: state %0d done %0b dir %0d mask %02h",
                             got_state, got_done, got_dir, got_mask);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got_state != want.run_state || got_done != want.run_done ||
                    got_dir != want.direction || got_mask != want.fired_mask ||
                    got_count != want.fired_count || got_dur != want.duration) begin
                    if (mismatch_count < 10) begin
                        $display("result mismatch at cycle %0d", cycle_count);
                        $display("  expected state %0d done %0b dir %0d mask %02h count %0d dur %08h",
                                 want.run_state, want.run_done, want.direction,
                                 want.fired_mask, want.fired_count, want.duration);
                        $display("  actual   state %0d done %0b dir %0d mask %02h count %0d dur %08h",
                                 got_state, got_done, got_dir, got_mask, got_count, got_dur);
                    end
                    mismatch_count++;
                end
            end
        end

        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
        end else if (quiet || $urandom_range(0, 3) != 0) begin
            m_tready   <= 1'b1;
            ready_hold = $urandom_range(0, 20);
        end else begin
            m_tready   <= 1'b0;
            ready_hold = gap_length();
        end
    end

    task automatic send_item(op_t op, logic [PORT_W-1:0] port, logic [TIME_W-1:0] ts,
                             logic [TIME_W-1:0] now);
        int gap;
        gap = source_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, ts, port};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_gate(op, port, ts, now);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (IDLE_PAD) @(posedge aclk);
    endtask

    task automatic write_setting(reg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TIMEOUT: cfg_timeout = value[TMO_W-1:0];
            REG_SETTLE:  cfg_settle  = value[SETL_W-1:0];
            REG_RETRIG:  cfg_retrig  = value[RETR_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] tmo, logic [CFG_W-1:0] settle,
                                  logic [CFG_W-1:0] retrig);
        drain_results();
        write_setting(REG_TIMEOUT, tmo);
        write_setting(REG_SETTLE, settle);
        write_setting(REG_RETRIG, retrig);
    endtask

    function automatic logic [CFG_W-1:0] pick_setting(int width);
        logic [CFG_W-1:0] full;
        full = CFG_W'((1 << width) - 1);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return full;
            2, 3: return CFG_W'($urandom_range(1, 2000));
            default: return CFG_W'($urandom) & full;
        endcase
    endfunction

    task automatic test_idle_items();
        send_item(OP_POLL, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_EVENT, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_DISARM, 8'hFF, 32'h1234_5678, 32'h0000_0010);
    endtask

    task automatic test_full_run();
        send_item(OP_ARM, 8'hFF, 32'd0, 32'd1000);
        send_item(OP_EVENT, 8'h00, 32'd4000, 32'd1050);   // inside settle window
        send_item(OP_EVENT, 8'hFE, 32'd5000, 32'd1100);   // first gate starts the run
        send_item(OP_EVENT, 8'h00, 32'd5500, 32'd1101);   // all held off by the guard
        send_item(OP_EVENT, 8'hF0, 32'd7000, 32'd1200);   // one more, rest guarded
        send_item(OP_POLL, 8'h00, 32'hFFFF_FFFF, 32'd1300);
        send_item(OP_EVENT, 8'h77, 32'd9000, 32'd1400);   // upper bits ignored
        send_item(OP_EVENT, 8'h0B, 32'd20000, 32'd1500);  // last gate completes
        send_item(OP_POLL, 8'h00, 32'd0, 32'd1600);
        send_item(OP_EVENT, 8'h00, 32'd30000, 32'd1700);  // dropped when complete
        send_item(OP_DISARM, 8'h00, 32'd0, 32'd1800);     // record still reported
    endtask

    task automatic test_timeout_run();
        send_item(OP_ARM, 8'hAA, 32'hDEAD_BEEF, 32'd50000);
        send_item(OP_EVENT, 8'hFD, 32'd100, 32'd50200);
        send_item(OP_EVENT, 8'hFB, 32'd2000, 32'd50300);  // no end gate yet
        send_item(OP_EVENT, 8'hF7, 32'd3500, 32'd50400);
        send_item(OP_EVENT, 8'h00, 32'd9000, 32'd60201);  // timeout drops the event
    endtask

    task automatic test_zero_settings();
        apply_settings(24'd0, 24'd0, 24'd0);
        send_item(OP_ARM, 8'h55, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_EVENT, 8'hF0, 32'h8000_0000, 32'hFFFF_FFFF);  // every gate at once
        send_item(OP_ARM, 8'h00, 32'd0, 32'h0000_0100);
        send_item(OP_EVENT, 8'hEE, 32'h0000_0001, 32'h0000_0100);
        send_item(OP_POLL, 8'hFF, 32'd0, 32'h0000_0100);
        send_item(OP_POLL, 8'hFF, 32'd0, 32'h0000_0101);
    endtask

    task automatic test_wrap_and_max();
        apply_settings(24'h00FFFF, 24'h00FFFF, 24'hFFFFFF);
        send_item(OP_ARM, 8'h0F, 32'd0, 32'hFFFF_FFF0);
        send_item(OP_EVENT, 8'h00, 32'd77, 32'h0000_FFEE);  // one short of settle
        send_item(OP_EVENT, 8'hF9, 32'hFFFF_FF00, 32'h0000_FFEF);
        send_item(OP_EVENT, 8'hF3, 32'h00FF_FF00, 32'h0001_0000);  // stamp wraps
        send_item(OP_POLL, 8'h00, 32'd0, 32'h0001_FFEE);
        send_item(OP_POLL, 8'h00, 32'd0, 32'h0001_FFEF);
    endtask

    // one arm followed by a run of mostly well-formed gate events
    task automatic random_run(int steps);
        int                r;
        int                k;
        logic [PORT_W-1:0] port;
        if ($urandom_range(0, 3) == 0) stream_now = $urandom;
        stream_us = $urandom;
        send_item(OP_ARM, PORT_W'($urandom), $urandom, stream_now);
        if (cfg_settle != 0 && $urandom_range(0, 2) == 0)
            send_item(OP_EVENT, PORT_W'($urandom), $urandom,
                      stream_now + $urandom_range(0, cfg_settle - 1));
        stream_now = stream_now + cfg_settle + $urandom_range(0, 3);
        repeat (steps) begin
            r = $urandom_range(0, 99);
            stream_now = stream_now + $urandom_range(0, cfg_timeout / 6);
            if (r < 6) stream_now = stream_now + cfg_timeout + 1 + $urandom_range(0, 50);
            if (r < 62) begin
                if (r < 50)
                    stream_us = stream_us + cfg_retrig + $urandom_range(0, 4000);
                else
                    stream_us = stream_us + $urandom_range(0, cfg_retrig);
                port = PORT_W'($urandom);
                if ($urandom_range(0, 4) != 0) begin
                    port[SENSOR_COUNT-1:0] = '1;
                    k = $urandom_range(0, SENSOR_COUNT - 1);
                    repeat (8) if (fired[k]) k = $urandom_range(0, SENSOR_COUNT - 1);
                    port[k] = 1'b0;
                end
                send_item(OP_EVENT, port, stream_us, stream_now);
            end else if (r < 75) begin
                send_item(OP_POLL, PORT_W'($urandom), $urandom, stream_now);
            end else if (r < 78) begin
                send_item(OP_DISARM, PORT_W'($urandom), $urandom, stream_now);
            end else if (r < 80) begin
                send_item(OP_ARM, PORT_W'($urandom), $urandom, stream_now);
            end else begin
                send_item(op_t'($urandom_range(0, 3)), PORT_W'($urandom), $urandom, $urandom);
            end
        end
    endtask

    task automatic test_random_phases();
        int start;
        for (int p = 0; p < 6; p++) begin
            if (p == 1)
                apply_settings(24'd0, 24'd0, 24'd0);
            else if (p == 2)
                apply_settings(24'h00FFFF, 24'h00FFFF, 24'hFFFFFF);
            else
                apply_settings(pick_setting(TMO_W), pick_setting(SETL_W), pick_setting(RETR_W));
            quiet = (p == 3);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) random_run($urandom_range(3, 9));
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        test_idle_items();
        test_full_run();
        test_timeout_run();
        test_zero_settings();
        test_wrap_and_max();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sgrt_pkg.sv
rtl/sgrt_ctrl.sv
rtl/sgrt_dp.sv
rtl/sensor_gate_run_timer_core.sv
tb/tb_top.sv
